### rtl/apu_pkg.sv
// ----------------------------------------------------------------------------
// apu_pkg
// Shared types and constants for the Adam parameter update block.
// ----------------------------------------------------------------------------
package apu_pkg;

   localparam int IDX_W   = 10;
   localparam int DATA_W  = 32;
   localparam int CSR_W   = 3;
   localparam int DEN_W   = 41;  // sqrt(v)*2^8 + eps' < 2^41
   localparam int QUOT_W  = 33;  // delta below the cap fits in 33 bits
   localparam int DELTA_W = 34;

   localparam logic [31:0]        Q131_ONE  = 32'h8000_0000;
   localparam logic [16:0]        Q16_ONE   = 17'h1_0000;
   localparam logic [DELTA_W-1:0] DELTA_CAP = 34'h2_0000_0000;

   // register indexes
   localparam logic [CSR_W-1:0] CSR_BETA_FIRST    = 3'd0;
   localparam logic [CSR_W-1:0] CSR_BETA_SECOND   = 3'd1;
   localparam logic [CSR_W-1:0] CSR_LEARNING_RATE = 3'd2;
   localparam logic [CSR_W-1:0] CSR_EPSILON       = 3'd3;
   localparam logic [CSR_W-1:0] CSR_CLIP_LIMIT    = 3'd4;

   typedef struct packed {
      logic                     new_step;
      logic [IDX_W-1:0]         param_index;
      logic signed [DATA_W-1:0] gradient;
      logic signed [DATA_W-1:0] param_value;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]         result_index;
      logic signed [DATA_W-1:0] updated_value;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic [63:0] radicand;
   } sqrt_cmd_type;

   typedef struct packed {
      logic              start;
      logic [DEN_W-1:0]  rem;   // dividend bits above the quotient, < den
      logic [QUOT_W-1:0] low;   // remaining dividend bits, left aligned
      logic [DEN_W-1:0]  den;
      logic [5:0]        bits;  // quotient bits to produce
   } div_cmd_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_LOAD,
      ST_P1, ST_P2, ST_P3, ST_R2_GO, ST_R2_WAIT, ST_LR, ST_RDIV, ST_RWAIT,
      ST_EPS, ST_EPS2,
      ST_M1, ST_M2, ST_M3, ST_V1, ST_V2, ST_V3, ST_V4,
      ST_VSQ, ST_VWAIT, ST_DIV, ST_DWAIT, ST_OUT
   } state_type;

endpackage

### rtl/apu_sqrt.sv
// ----------------------------------------------------------------------------
// apu_sqrt
// Iterative integer square root, 64-bit radicand, one result bit per cycle.
// ----------------------------------------------------------------------------
module apu_sqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  apu_pkg::sqrt_cmd_type cmd,
   output logic                  done,
   output logic [31:0]           root
);
   import apu_pkg::*;

   logic        busy_ff, done_ff;
   logic [5:0]  cnt_ff;
   logic [63:0] x_ff;
   logic [33:0] rem_ff;
   logic [31:0] root_ff;

   logic [35:0] part;
   logic [35:0] trial;
   logic        ge;

   always_comb begin
      part  = {rem_ff, x_ff[63:62]};
      trial = {2'b00, root_ff, 2'b01};
      ge    = part >= trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'd32;
            x_ff    <= cmd.radicand;
            rem_ff  <= '0;
            root_ff <= '0;
         end else if (busy_ff) begin
            x_ff    <= {x_ff[61:0], 2'b00};
            rem_ff  <= ge ? 34'(part - trial) : part[33:0];
            root_ff <= {root_ff[30:0], ge};
            cnt_ff  <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

### rtl/apu_div.sv
// ----------------------------------------------------------------------------
// apu_div
// Restoring divider, one quotient bit per cycle, caller checks overflow.
// ----------------------------------------------------------------------------
module apu_div (
   input  logic                         clock,
   input  logic                         reset,
   input  apu_pkg::div_cmd_type         cmd,
   output logic                         done,
   output logic [apu_pkg::QUOT_W-1:0]   quot
);
   import apu_pkg::*;

   logic              busy_ff, done_ff;
   logic [5:0]        cnt_ff;
   logic [DEN_W-1:0]  rem_ff, den_ff;
   logic [QUOT_W-1:0] low_ff, quot_ff;

   logic [DEN_W:0] trial;
   logic           ge;

   always_comb begin
      trial = {rem_ff, low_ff[QUOT_W-1]};
      ge    = trial >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= cmd.bits;
            rem_ff  <= cmd.rem;
            low_ff  <= cmd.low;
            den_ff  <= cmd.den;
            quot_ff <= '0;
         end else if (busy_ff) begin
            rem_ff  <= ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
            low_ff  <= {low_ff[QUOT_W-2:0], 1'b0};
            quot_ff <= {quot_ff[QUOT_W-2:0], ge};
            cnt_ff  <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

### rtl/adam_parameter_update.sv
// ----------------------------------------------------------------------------
// adam_parameter_update
// Adam optimizer update with gradient clipping, one parameter per beat.
// ----------------------------------------------------------------------------
//  channel | ports                        | beat
//  --------+------------------------------+---------------------------------
//  request | req_valid/req_ready/req_data | new_step, index, gradient, value
//  result  | rsp_valid/rsp_ready/rsp_data | index, updated value
//  csr     | csr_we/csr_index/csr_data    | register write, no wait
//
//  One beat at a time. A plain beat goes from accept to result through
//  nine load, multiply and store steps, a wait on the 32-bit root of v, the
//  range check, the 33-bit divide unless the check skips it, and the
//  output step. A new_step beat adds the root of 1 - b2^t and a 32-bit
//  rate divide, which is skipped when 1 - b1^t is zero or the quotient
//  would overflow. After reset the moment memories are swept to zero
//  with req_ready low. A result waiting in the output register does not
//  stop the next request from being taken.
// ----------------------------------------------------------------------------
module adam_parameter_update #(
   parameter int PARAM_COUNT = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  apu_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output apu_pkg::rsp_type  rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_data
);
   import apu_pkg::*;

   localparam int AW = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;

   // configuration
   logic [15:0] beta_first_ff, beta_second_ff;
   logic [23:0] learning_rate_ff;
   logic [31:0] epsilon_ff;
   logic [30:0] clip_limit_ff;

   // step state
   logic [31:0] step_count_ff, bfp_ff, bsp_ff, rate_ff, seps_ff, r2_ff;

   // item state
   state_type             state_ff, state_in;
   req_type               item_ff;
   logic                  hit_ff;           // index lies inside the memory
   logic signed [31:0]    g_ff, m_ff;
   logic [31:0]           v_ff;
   logic [45:0]           gsq_ff;
   logic signed [65:0]    acc_ff;
   logic [DEN_W-1:0]      den_ff;
   logic [DELTA_W-1:0]    delta_ff;
   logic [AW-1:0]         clear_cnt_ff;

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   // shared multiplier, product held unless a multiply state runs
   logic               mul_en;
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod_ff;

   // moment memories
   logic signed [31:0] m_mem [PARAM_COUNT];
   logic [31:0]        v_mem [PARAM_COUNT];
   logic signed [31:0] m_rd_ff;
   logic [31:0]        v_rd_ff;
   logic               mem_we;
   logic [AW-1:0]      mem_wa;
   logic signed [31:0] mem_wm;
   logic [31:0]        mem_wv;

   sqrt_cmd_type sqrt_cmd;
   logic         sqrt_done;
   logic [31:0]  sqrt_root;
   div_cmd_type  div_cmd;
   logic         div_done;
   logic [QUOT_W-1:0] div_quot;

   // datapath helpers
   logic        req_fire, out_load;
   logic [31:0] d1, mag_g, mag_m;
   logic [63:0] num;
   logic signed [65:0] msum, vsum;
   logic [31:0] v_new;
   logic signed [32:0] g_ext, clip_ext;
   logic signed [31:0] g_clip;
   logic signed [35:0] res_full;
   logic signed [31:0] res_sat;

   assign req_fire = req_valid && req_ready;
   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      d1    = Q131_ONE - bfp_ff;
      mag_g = g_ff[31] ? 32'(-g_ff) : g_ff;
      mag_m = m_ff[31] ? 32'(32'd0 - m_ff) : m_ff;
      num   = prod_ff[63:0];
      msum  = acc_ff + prod_ff;
      vsum  = acc_ff + (prod_ff <<< 23);
      v_new = (|vsum[65:48]) ? 32'hFFFF_FFFF : vsum[47:16];

      g_ext    = {req_data.gradient[31], req_data.gradient};
      clip_ext = {2'b00, clip_limit_ff};
      if (g_ext > clip_ext)
         g_clip = 32'(clip_ext);
      else if (g_ext < -clip_ext)
         g_clip = 32'(-clip_ext);
      else
         g_clip = req_data.gradient;

      if (m_ff[31])
         res_full = {{4{item_ff.param_value[31]}}, item_ff.param_value} +
                    $signed({2'b00, delta_ff});
      else
         res_full = {{4{item_ff.param_value[31]}}, item_ff.param_value} -
                    $signed({2'b00, delta_ff});
      if (res_full > 36'sh0_7FFF_FFFF)
         res_sat = 32'sh7FFF_FFFF;
      else if (res_full < -36'sh0_8000_0000)
         res_sat = -32'sh8000_0000;
      else
         res_sat = res_full[31:0];
   end

   // --- control ------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_CLEAR;
      else
         state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      mul_en    = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      mem_we    = 1'b0;
      mem_wa    = clear_cnt_ff;
      mem_wm    = '0;
      mem_wv    = '0;
      sqrt_cmd  = '0;
      div_cmd   = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            if (clear_cnt_ff == AW'(PARAM_COUNT - 1))
               state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid)
               state_in = ST_LOAD;
         end
         ST_LOAD: state_in = item_ff.new_step ? ST_P1 : ST_M1;
         // optimizer step start
         ST_P1: begin
            mul_en = 1'b1;
            mul_a  = {1'b0, bfp_ff};
            mul_b  = {17'd0, beta_first_ff};
            state_in = ST_P2;
         end
         ST_P2: begin
            mul_en = 1'b1;
            mul_a  = {1'b0, bsp_ff};
            mul_b  = {17'd0, beta_second_ff};
            state_in = ST_P3;
         end
         ST_P3: state_in = ST_R2_GO;
         ST_R2_GO: begin
            sqrt_cmd.start    = 1'b1;
            sqrt_cmd.radicand = {1'b0, Q131_ONE - bsp_ff, 31'd0};
            state_in = ST_R2_WAIT;
         end
         ST_R2_WAIT: if (sqrt_done) state_in = ST_LR;
         ST_LR: begin
            mul_en = 1'b1;
            mul_a  = {9'd0, learning_rate_ff};
            mul_b  = {1'b0, r2_ff};
            state_in = ST_RDIV;
         end
         ST_RDIV: begin
            if (d1 == '0 || {8'd0, num[55:32]} >= d1) begin
               state_in = ST_EPS;
            end else begin
               div_cmd.start = 1'b1;
               div_cmd.rem   = DEN_W'(num[55:32]);
               div_cmd.low   = {num[31:0], 1'b0};
               div_cmd.den   = DEN_W'(d1);
               div_cmd.bits  = 6'd32;
               state_in = ST_RWAIT;
            end
         end
         ST_RWAIT: if (div_done) state_in = ST_EPS;
         ST_EPS: begin
            mul_en = 1'b1;
            mul_a  = {1'b0, epsilon_ff};
            mul_b  = {1'b0, r2_ff};
            state_in = ST_EPS2;
         end
         ST_EPS2: state_in = ST_M1;
         // moment update
         ST_M1: begin
            mul_en = 1'b1;
            mul_a  = {17'd0, beta_first_ff};
            mul_b  = {m_ff[31], m_ff};
            state_in = ST_M2;
         end
         ST_M2: begin
            mul_en = 1'b1;
            mul_a  = {16'd0, Q16_ONE - {1'b0, beta_first_ff}};
            mul_b  = {g_ff[31], g_ff};
            state_in = ST_M3;
         end
         ST_M3: begin
            mul_en = 1'b1;
            mul_a  = {1'b0, mag_g};
            mul_b  = {1'b0, mag_g};
            state_in = ST_V1;
         end
         ST_V1: begin
            mul_en = 1'b1;
            mul_a  = {17'd0, beta_second_ff};
            mul_b  = {1'b0, v_ff};
            state_in = ST_V2;
         end
         ST_V2: begin
            mul_en = 1'b1;
            mul_a  = {16'd0, Q16_ONE - {1'b0, beta_second_ff}};
            mul_b  = {10'd0, gsq_ff[22:0]};
            state_in = ST_V3;
         end
         ST_V3: begin
            mul_en = 1'b1;
            mul_a  = {16'd0, Q16_ONE - {1'b0, beta_second_ff}};
            mul_b  = {10'd0, gsq_ff[45:23]};
            state_in = ST_V4;
         end
         ST_V4: begin
            mem_we = hit_ff;
            mem_wa = AW'(item_ff.param_index);
            mem_wm = m_ff;
            mem_wv = v_new;
            state_in = ST_VSQ;
         end
         ST_VSQ: begin
            sqrt_cmd.start    = 1'b1;
            sqrt_cmd.radicand = {v_ff, 32'd0};
            mul_en = 1'b1;
            mul_a  = {1'b0, rate_ff};
            mul_b  = {1'b0, mag_m};
            state_in = ST_VWAIT;
         end
         ST_VWAIT: if (sqrt_done) state_in = ST_DIV;
         // delta = rate*|m|*2^8 / den, capped
         ST_DIV: begin
            if (num == '0 || {2'b00, num[63:25]} >= den_ff) begin
               state_in = ST_OUT;
            end else begin
               div_cmd.start = 1'b1;
               div_cmd.rem   = {2'b00, num[63:25]};
               div_cmd.low   = {num[24:0], 8'd0};
               div_cmd.den   = den_ff;
               div_cmd.bits  = 6'd33;
               state_in = ST_DWAIT;
            end
         end
         ST_DWAIT: if (div_done) state_in = ST_OUT;
         ST_OUT: if (out_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // --- datapath -----------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mul_en)
         prod_ff <= mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beta_first_ff    <= 16'd58982;
         beta_second_ff   <= 16'd65470;
         learning_rate_ff <= 24'd16777;
         epsilon_ff       <= 32'd43;
         clip_limit_ff    <= 31'd65536;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BETA_FIRST:    beta_first_ff    <= csr_data[15:0];
            CSR_BETA_SECOND:   beta_second_ff   <= csr_data[15:0];
            CSR_LEARNING_RATE: learning_rate_ff <= csr_data[23:0];
            CSR_EPSILON:       epsilon_ff       <= csr_data;
            CSR_CLIP_LIMIT:    clip_limit_ff    <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_count_ff <= '0;
         bfp_ff        <= Q131_ONE;
         bsp_ff        <= Q131_ONE;
         rate_ff       <= '0;
         seps_ff       <= '0;
         clear_cnt_ff  <= '0;
      end else begin
         if (state_ff == ST_CLEAR)
            clear_cnt_ff <= clear_cnt_ff + AW'(1);
         case (state_ff)
            ST_P1:      step_count_ff <= step_count_ff + 32'd1;
            ST_P2:      bfp_ff <= prod_ff[47:16];
            ST_P3:      bsp_ff <= prod_ff[47:16];
            ST_RDIV: begin
               if (d1 == '0)
                  rate_ff <= '0;
               else if ({8'd0, num[55:32]} >= d1)
                  rate_ff <= 32'hFFFF_FFFF;
            end
            ST_RWAIT:   if (div_done) rate_ff <= div_quot[31:0];
            ST_EPS2:    seps_ff <= prod_ff[62:31];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= req_data;
         hit_ff  <= 32'(req_data.param_index) < PARAM_COUNT;
         g_ff    <= g_clip;
      end
      case (state_ff)
         ST_LOAD: begin
            m_ff <= hit_ff ? m_rd_ff : '0;
            v_ff <= hit_ff ? v_rd_ff : '0;
         end
         ST_R2_WAIT: if (sqrt_done) r2_ff <= sqrt_root;
         ST_M2:      acc_ff <= prod_ff;
         ST_M3:      m_ff   <= msum[47:16];
         ST_V1:      gsq_ff <= prod_ff[61:16];
         ST_V2:      acc_ff <= prod_ff;
         ST_V3:      acc_ff <= msum;
         ST_V4:      v_ff   <= v_new;
         ST_VWAIT:   if (sqrt_done) den_ff <= {1'b0, sqrt_root, 8'd0} + DEN_W'(seps_ff);
         ST_DIV: begin
            if (num == '0)
               delta_ff <= '0;
            else if ({2'b00, num[63:25]} >= den_ff)
               delta_ff <= DELTA_CAP;
         end
         ST_DWAIT:   if (div_done) delta_ff <= {1'b0, div_quot};
         default: ;
      endcase
   end

   // --- memories -----------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         m_mem[mem_wa] <= mem_wm;
         v_mem[mem_wa] <= mem_wv;
      end
      if (req_fire) begin
         m_rd_ff <= m_mem[AW'(req_data.param_index)];
         v_rd_ff <= v_mem[AW'(req_data.param_index)];
      end
   end

   // --- output register ----------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         rsp_data_ff.result_index  <= item_ff.param_index;
         rsp_data_ff.updated_value <= res_sat;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   apu_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .cmd   (sqrt_cmd),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   apu_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .done  (div_done),
      .quot  (div_quot)
   );

   // --- assertions ---------------------------------------------------------
   // one beat in flight: an accepted request always goes to the load step
   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_LOAD))
      else $error("request not followed by load");

   // no result can appear while the memories are being swept
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff)
      else $error("result during memory sweep");

   // rate divide was range checked, so its quotient fits 32 bits
   a_rate_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RWAIT && div_done) |-> !div_quot[QUOT_W-1])
      else $error("rate quotient overflow");

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for adam_parameter_update: random request and result
// pacing, an in-bench Adam predictor, and in-order checks of every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
   import apu_pkg::*;

   localparam int PCOUNT   = 1024;
   localparam int MAX_WAIT = 13;
   localparam logic [CSR_W-1:0] CSR_UNUSED = 3'd7;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   adam_parameter_update #(.PARAM_COUNT(PCOUNT)) i_dut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_we, .csr_index, .csr_data
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor state: registers, optimizer step state and moment memories
   // ---------------------------------------------------------------------
   logic [15:0] cfg_b1, cfg_b2;
   logic [23:0] cfg_lr;
   logic [31:0] cfg_eps;
   logic [30:0] cfg_clip;
   logic signed [31:0] m_mem [PCOUNT];
   logic [31:0] v_mem [PCOUNT];
   logic [31:0] b1_pow, b2_pow, rate_t, eps_t;

   req_type pending_beats [$];
   rsp_type expected_rsp [$];
   int      mismatches = 0;
   logic    stim_done = 1'b0;

   function automatic logic [63:0] int_sqrt(input logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   task automatic model_reset();
      foreach (m_mem[i]) begin
         m_mem[i] = 0;
         v_mem[i] = 0;
      end
      b1_pow = Q131_ONE;
      b2_pow = Q131_ONE;
      rate_t = 0;
      eps_t = 0;
      cfg_b1 = 16'd58982;
      cfg_b2 = 16'd65470;
      cfg_lr = 24'd16777;
      cfg_eps = 32'd43;
      cfg_clip = 31'd65536;
   endtask

   function automatic void advance_step();
      logic [63:0] d1, d2, r2, q;
      b1_pow = 32'((64'(b1_pow) * cfg_b1) >> 16);
      b2_pow = 32'((64'(b2_pow) * cfg_b2) >> 16);
      d1 = 64'(Q131_ONE) - b1_pow;
      d2 = 64'(Q131_ONE) - b2_pow;
      r2 = int_sqrt(d2 << 31);
      if (d1 == 0) begin
         rate_t = 0;
      end else begin
         q = (64'(cfg_lr) * r2) / d1;
         rate_t = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
      end
      eps_t = 32'((64'(cfg_eps) * r2) >> 31);
   endfunction

   // one beat through the optimizer, returns the expected result
   function automatic rsp_type adam_update(input req_type b);
      logic signed [63:0] g, clip, m, sum, res;
      logic [63:0] v, mag, gsq, den, num, q, r, delta;
      logic ok;
      rsp_type o;
      ok = b.param_index < PCOUNT;
      if (b.new_step) advance_step();
      g = 64'(b.gradient);
      clip = 64'(cfg_clip);
      if (g > clip) g = clip;
      if (g < -clip) g = -clip;
      m = ok ? 64'(m_mem[b.param_index]) : 0;
      v = ok ? 64'(v_mem[b.param_index]) : 0;
      sum = 64'(cfg_b1) * m + (64'sd65536 - cfg_b1) * g;
      m = sum >>> 16;                       // arithmetic shift is floor
      mag = (g < 0) ? -g : g;
      gsq = (mag * mag) >> 16;
      v = (64'(cfg_b2) * v + (64'd65536 - cfg_b2) * gsq) >> 16;
      if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
      if (ok) begin
         m_mem[b.param_index] = m[31:0];
         v_mem[b.param_index] = v[31:0];
      end
      den = (int_sqrt(v << 32) << 8) + eps_t;
      mag = (m < 0) ? -m : m;
      num = 64'(rate_t) * mag;
      if (num == 0) begin
         delta = 0;
      end else if (den == 0) begin
         delta = 64'(DELTA_CAP);
      end else begin
         q = num / den;
         r = num % den;
         delta = (q >= (64'd1 << 25)) ? 64'(DELTA_CAP) : (q << 8) + ((r << 8) / den);
      end
      res = (m < 0) ? 64'(b.param_value) + signed'(delta)
                    : 64'(b.param_value) - signed'(delta);
      if (res > 64'sd2147483647) res = 64'sd2147483647;
      if (res < -64'sd2147483648) res = -64'sd2147483648;
      o.result_index = b.param_index;
      o.updated_value = res[31:0];
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Driver: one beat per pending entry, random gap before each
   // ---------------------------------------------------------------------
   int   req_gap = 0;
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;

   // beat taken at this rising edge; predict it now
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         expected_rsp.push_back(adam_update(req_data));
         void'(pending_beats.pop_front());
         req_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) begin
            req_taken = 1'b0;
            req_gap = $urandom_range(0, MAX_WAIT);
            if ($urandom_range(0, 3) == 0) req_gap = 0;
         end
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_beats.size() > 0) begin
            req_valid <= 1'b1;
            req_data <= pending_beats[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: check at the rising edge, pace rsp_ready at the falling edge
   // ---------------------------------------------------------------------
   int rsp_gap = 0;
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_taken = 1'b1;
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: idx %0d value %0d",
                        rsp_data.result_index, rsp_data.updated_value);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.result_index !== want.result_index ||
                rsp_data.updated_value !== want.updated_value) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: idx exp %0d got %0d, value exp %0d got %0d",
                           want.result_index, rsp_data.result_index,
                           want.updated_value, rsp_data.updated_value);
            end
         end
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            rsp_gap = $urandom_range(0, MAX_WAIT);
            if ($urandom_range(0, 3) == 0) rsp_gap = 0;
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_BETA_FIRST:    cfg_b1 = val[15:0];
         CSR_BETA_SECOND:   cfg_b2 = val[15:0];
         CSR_LEARNING_RATE: cfg_lr = val[23:0];
         CSR_EPSILON:       cfg_eps = val;
         CSR_CLIP_LIMIT:    cfg_clip = val[30:0];
         default: ;
      endcase
   endtask

   // wait for all beats out, plus drain margin before touching registers
   task automatic drain();
      while (pending_beats.size() > 0 || expected_rsp.size() > 0 || req_valid)
         @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   function automatic req_type mk(input logic ns, input logic [9:0] idx,
                                  input logic [31:0] g, input logic [31:0] v);
      req_type b;
      b.new_step = ns;
      b.param_index = idx;
      b.gradient = g;
      b.param_value = v;
      return b;
   endfunction

   // gradient evenly from four kinds: any 32-bit pattern, within +-2^17, a signed extreme, or within +-512
   function automatic logic [31:0] rand_grad();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 4 * 65536)) - 2 * 65536);
         2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 1024)) - 512);
      endcase
   endfunction

   task automatic random_phase(input int beats);
      int n;
      logic [9:0] base;
      n = 0;
      while (n < beats) begin
         // a step: a run over a small index window, new_step now and then, then a new_step beat at the base
         base = $urandom_range(0, 1023);
         for (int k = $urandom_range(1, 12); k > 0 && n < beats; k--) begin
            pending_beats.push_back(mk(k == 0 ? 1'b0 : ($urandom_range(0, 15) == 0),
                                       10'(base + $urandom_range(0, 7)),
                                       rand_grad(), $urandom));
            n++;
         end
         pending_beats[pending_beats.size() - 1].new_step = pending_beats.size() == 0;
         pending_beats.push_back(mk(1'b1, base, rand_grad(), $urandom));
         n++;
      end
   endtask

   initial begin
      model_reset();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // no step started yet: values pass through, moments still move
      pending_beats.push_back(mk(1'b0, 10'd5, 32'h0001_0000, 32'h1234_5678));
      pending_beats.push_back(mk(1'b0, 10'd5, 32'h8000_0000, 32'h8000_0000));
      // first steps, clip extremes, index extremes
      pending_beats.push_back(mk(1'b1, 10'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      pending_beats.push_back(mk(1'b0, 10'd1023, 32'h8000_0000, 32'h8000_0000));
      pending_beats.push_back(mk(1'b0, 10'd0, 32'h0, 32'h0));
      pending_beats.push_back(mk(1'b0, 10'd5, 32'hFFFF_FFFF, 32'h7FFF_FFF0));
      pending_beats.push_back(mk(1'b1, 10'd1023, 32'h0000_0100, 32'h8000_0010));
      pending_beats.push_back(mk(1'b0, 10'd512, 32'hFFFF_0000, 32'hFFFF_FFFF));
      drain();

      // beta_first of zero: the bias power drops to zero on the first step
      // zero epsilon leaves only the scaled root of v in the divisor
      csr_write(CSR_BETA_FIRST, 32'h0);
      csr_write(CSR_EPSILON, 32'h0);
      csr_write(CSR_CLIP_LIMIT, 32'h7FFF_FFFF);
      csr_write(CSR_UNUSED, 32'hFFFF_FFFF);  // unused index, ignored
      pending_beats.push_back(mk(1'b1, 10'd100, 32'h0001_0000, 32'h0));
      pending_beats.push_back(mk(1'b0, 10'd101, 32'h7FFF_FFFF, 32'h1));
      drain();
      csr_write(CSR_BETA_FIRST, 32'hFFFF);
      csr_write(CSR_BETA_SECOND, 32'h0);
      csr_write(CSR_LEARNING_RATE, 32'hFF_FFFF);
      pending_beats.push_back(mk(1'b1, 10'd200, 32'h0000_0001, 32'h7FFF_FFFF));
      pending_beats.push_back(mk(1'b0, 10'd200, 32'h8000_0000, 32'h8000_0000));
      pending_beats.push_back(mk(1'b1, 10'd201, 32'h7FFF_FFFF, 32'h8000_0000));
      pending_beats.push_back(mk(1'b0, 10'd201, 32'h0, 32'h7FFF_FFFF));
      drain();

      // random phases across several register settings
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin
               csr_write(CSR_BETA_FIRST, 32'd58982);
               csr_write(CSR_BETA_SECOND, 32'd65470);
               csr_write(CSR_LEARNING_RATE, 32'd16777);
               csr_write(CSR_EPSILON, 32'd43);
               csr_write(CSR_CLIP_LIMIT, 32'd65536);
            end
            1: begin
               csr_write(CSR_CLIP_LIMIT, 32'h0);
               csr_write(CSR_EPSILON, 32'hFFFF_FFFF);
            end
            default: begin
               csr_write(CSR_BETA_FIRST, $urandom_range(0, 65535));
               csr_write(CSR_BETA_SECOND, $urandom_range(0, 65535));
               csr_write(CSR_LEARNING_RATE, $urandom_range(0, 24'hFF_FFFF));
               csr_write(CSR_EPSILON, $urandom);
               csr_write(CSR_CLIP_LIMIT, $urandom_range(0, 32'h7FFF_FFFF));
            end
         endcase
         random_phase(185);
         drain();
      end
      stim_done = 1'b1;
   end

   // ---------------------------------------------------------------------
   // End of run and watchdog
   // ---------------------------------------------------------------------
   initial begin
      wait (stim_done);
      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("adam_parameter_update regression: pass");
      end else begin
         $display("adam_parameter_update regression: fail");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("adam_parameter_update regression: fail");
      $finish;
   end

endmodule
